>>> src/assert_macros.svh
// Assertion macros used by the top level RTL file of the comma list splitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or plain property checked on every clock edge outside reset.
`define ESCL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define ESCL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> src/escl_pkg.sv
// Shared constants and types of the escaped comma list splitter.
`timescale 1ns / 1ps
`default_nettype none

package escl_pkg;

  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // Result queue sizing: room for two results per input byte plus slack.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic       list_end;
    logic       bad_quoting;
    logic       item_end;
    logic [7:0] out_byte;
    logic       has_byte;
  } res_t;

  // Results produced by one input byte, to the result queue.
  typedef struct packed {
    logic p0;
    logic p1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

`default_nettype wire

>>> src/escl_decode.sv
// Per-byte splitting, unquoting and unescaping with the item state registers.
`timescale 1ns / 1ps
`default_nettype none

module escl_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fire,
  input  wire logic [7:0]    in_byte,
  input  wire logic          last_byte,
  output escl_pkg::push_t    push
);
  import escl_pkg::*;

  logic       at_start_r, at_start_nxt;
  logic       quoted_r, quoted_nxt;
  logic       held_valid_r, held_valid_nxt;
  logic [7:0] held_raw_r, held_raw_nxt;
  logic       esc_r, esc_nxt;
  logic       bs_odd_r, bs_odd_nxt;

  logic       comma_ends;
  logic       dec_has;
  logic [7:0] dec_byte;
  logic       dec_esc;

  // unescape of the held byte
  always_comb begin
    dec_has  = 1'b1;
    dec_byte = held_raw_r;
    dec_esc  = esc_r;
    if (esc_r) begin
      dec_esc = 1'b0;
      case (held_raw_r)
        CH_T:    dec_byte = CH_TAB;
        CH_R:    dec_byte = CH_CR;
        CH_N:    dec_byte = CH_LF;
        default: dec_byte = held_raw_r;
      endcase
    end else if (held_raw_r == CH_BSLASH) begin
      dec_has = 1'b0;
      dec_esc = 1'b1;
    end
  end

  always_comb begin
    comma_ends     = (in_byte == CH_COMMA) && !bs_odd_r;
    at_start_nxt   = at_start_r;
    quoted_nxt     = quoted_r;
    held_valid_nxt = held_valid_r;
    held_raw_nxt   = held_raw_r;
    esc_nxt        = esc_r;
    bs_odd_nxt     = (in_byte == CH_BSLASH) ? !bs_odd_r : 1'b0;
    push           = '0;

    if (comma_ends) begin
      push.p0             = 1'b1;
      push.r0.item_end    = 1'b1;
      push.r0.bad_quoting = quoted_r && !(held_valid_r && held_raw_r == CH_QUOTE);
      push.p1             = last_byte;
      push.r1.item_end    = 1'b1;
      push.r1.list_end    = 1'b1;
      at_start_nxt        = 1'b1;
      quoted_nxt          = 1'b0;
      held_valid_nxt      = 1'b0;
      held_raw_nxt        = '0;
      esc_nxt             = 1'b0;
    end else if (at_start_r && in_byte == CH_QUOTE) begin
      at_start_nxt   = 1'b0;
      quoted_nxt     = 1'b1;
      held_valid_nxt = 1'b0;
      esc_nxt        = 1'b0;
      if (last_byte) begin
        push.p0             = 1'b1;
        push.r0.item_end    = 1'b1;
        push.r0.bad_quoting = 1'b1;
        push.r0.list_end    = 1'b1;
      end
    end else if (at_start_r || !quoted_r) begin
      at_start_nxt     = 1'b0;
      push.p0          = 1'b1;
      push.r0.has_byte = 1'b1;
      push.r0.out_byte = in_byte;
      push.r0.item_end = last_byte;
      push.r0.list_end = last_byte;
    end else if (last_byte) begin
      push.p0             = 1'b1;
      push.r0.has_byte    = held_valid_r && dec_has;
      push.r0.out_byte    = (held_valid_r && dec_has) ? dec_byte : 8'h00;
      push.r0.item_end    = 1'b1;
      push.r0.bad_quoting = (in_byte != CH_QUOTE);
      push.r0.list_end    = 1'b1;
    end else begin
      if (held_valid_r) begin
        push.p0          = dec_has;
        push.r0.has_byte = 1'b1;
        push.r0.out_byte = dec_byte;
        esc_nxt          = dec_esc;
      end
      held_raw_nxt   = in_byte;
      held_valid_nxt = 1'b1;
    end

    // end of list: everything back to reset values
    if (last_byte) begin
      at_start_nxt   = 1'b1;
      quoted_nxt     = 1'b0;
      held_valid_nxt = 1'b0;
      held_raw_nxt   = '0;
      esc_nxt        = 1'b0;
      bs_odd_nxt     = 1'b0;
    end

    if (!fire) begin
      push.p0 = 1'b0;
      push.p1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_start_r   <= 1'b1;
      quoted_r     <= 1'b0;
      held_valid_r <= 1'b0;
      held_raw_r   <= '0;
      esc_r        <= 1'b0;
      bs_odd_r     <= 1'b0;
    end else if (fire) begin
      at_start_r   <= at_start_nxt;
      quoted_r     <= quoted_nxt;
      held_valid_r <= held_valid_nxt;
      held_raw_r   <= held_raw_nxt;
      esc_r        <= esc_nxt;
      bs_odd_r     <= bs_odd_nxt;
    end
  end

endmodule

`default_nettype wire

>>> src/escl_result_fifo.sv
// Small result queue taking up to two results per cycle and giving one.
`timescale 1ns / 1ps
`default_nettype none

module escl_result_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire escl_pkg::push_t             push,
  input  wire logic                        pop,
  output escl_pkg::res_t                   head,
  output logic                             not_empty,
  output logic [escl_pkg::FIFO_CW-1:0]     level
);
  import escl_pkg::*;

  res_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic [FIFO_AW-1:0] wr_ptr_1;

  assign head      = mem_r[rd_ptr_r];
  assign not_empty = (cnt_r != '0);
  assign level     = cnt_r;
  assign wr_ptr_1  = wr_ptr_r + FIFO_AW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.p0) + FIFO_AW'(push.p1);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    cnt_nxt    = cnt_r + FIFO_CW'(push.p0) + FIFO_CW'(push.p1) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.p0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.p1) begin
      mem_r[wr_ptr_1] <= push.r1;
    end
  end

endmodule

`default_nettype wire

>>> src/escaped_comma_list_splitter.sv
// Top level of the escaped comma list splitter: input stage, decoder, result queue.
//
// Usage:
//   in_* channel takes the raw list one byte per transfer; in_tlast marks the
//   final byte of the list. An empty list is never presented.
//   out_* channel gives one result per transfer: out_tdata is the decoded byte
//   (zero when out_tuser has_byte is low), out_tuser carries has_byte,
//   item_end and bad_quoting, out_tlast marks the last result of the list.
//   A byte gives none, one or two results; two only for a comma that ends
//   the list (the item end, then an empty trailing item).
// Timing:
//   An input byte is registered in the input stage, decoded from there, and its
//   results are registered in the result queue, which offers them. One byte is
//   taken every cycle while out_tready stays high and the queue has room for two
//   results; a list-ending comma adds one result, held in the four-entry queue.
// Reset and stalls:
//   rst_n (synchronous, active low) empties the input stage and the queue and
//   returns the item state to the start of a list. When the receiver stalls,
//   the queue fills; once fewer than two free entries remain the input stage
//   holds its byte and in_tready drops until space frees up.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module escaped_comma_list_splitter (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // last_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic [2:0]      out_tuser,  // [0] has_byte, [1] item_end, [2] bad_quoting
  output logic            out_tlast   // list_end
);
  import escl_pkg::*;

  localparam logic [FIFO_CW-1:0] SPACE_LIM = FIFO_CW'(FIFO_DEPTH - 2);

  // input stage
  logic       v_r, v_nxt;
  logic [7:0] byte_r;
  logic       last_r;

  logic               in_xfer;
  logic               fire;
  logic               pop;
  logic [FIFO_CW-1:0] level;
  logic               not_empty;
  push_t              push;
  res_t               head;

  assign in_xfer   = in_tvalid && in_tready;
  // decode only when the queue can take both possible results
  assign fire      = v_r && (level <= SPACE_LIM);
  assign in_tready = !v_r || fire;
  assign pop       = out_tvalid && out_tready;

  always_comb begin
    v_nxt = v_r;
    if (in_xfer) begin
      v_nxt = 1'b1;
    end else if (fire) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_tdata;
      last_r <= in_tlast;
    end
  end

  escl_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .in_byte  (byte_r),
    .last_byte(last_r),
    .push     (push)
  );

  escl_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .not_empty(not_empty),
    .level    (level)
  );

  assign out_tvalid = not_empty;
  assign out_tdata  = head.out_byte;
  assign out_tuser  = {head.bad_quoting, head.item_end, head.has_byte};
  assign out_tlast  = head.list_end;

  // queue never overfills
  `ESCL_NEVER(a_fifo_over, level > FIFO_CW'(FIFO_DEPTH), "result queue over capacity")
  // a second result only follows a list-ending item end
  `ESCL_ASSERT(a_two_results, push.p1 |-> (push.p0 && push.r0.item_end && last_r),
               "second result without list-ending comma")
  // a byte held in the input stage waits unchanged until decoded
  `ESCL_ASSERT(a_stage_hold, (v_r && !fire) |=> (v_r && $stable(byte_r) && $stable(last_r)),
               "input stage lost a waiting byte")
  // the decoder only pushes for a held byte
  `ESCL_ASSERT(a_push_fire, push.p0 |-> fire, "result pushed without a decoded byte")

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking stream bench for the escaped comma list splitter.
`timescale 1ns / 1ps

module tb_top;
  import escl_pkg::*;

  // Cycles without any transfer on either side before the run is abandoned.
  localparam int QUIET_LIMIT   = 5000;
  // Long receiver hold-off, in cycles, to fill the result queue.
  localparam int HOLD_CYCLES   = 60;
  // Minimum random bytes offered per phase (three phases).
  localparam int PHASE_BYTES   = 330;
  // Cycles allowed after the last expected result, covering the pipeline.
  localparam int DRAIN_CYCLES  = 10;

  // One raw byte of a list as the sender offers it.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } list_byte_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;   // [7:0] out_byte
  logic [2:0] out_tuser;   // [0] has_byte, [1] item_end, [2] bad_quoting
  logic       out_tlast;   // list_end

  list_byte_t list_bytes_q[$];        // bytes waiting to be offered
  res_t       expected_results_q[$];  // predicted results, oldest first

  // Phase 0: sender lazy, receiver very lazy; 1: the other way round; 2: flat out.
  int phase        = 0;
  int accepted_cnt = 0;
  int hold_at      = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int quiet_cycles = 0;
  int err_cnt      = 0;
  int results_seen = 0;
  int lists_done   = 0;
  int bad_seen     = 0;

  // Splitter state as the predictor tracks it.
  logic       at_start;
  logic       in_quotes;
  logic       held_v;
  logic [7:0] held_b;
  logic       esc_pend;
  logic       bs_odd;

  escaped_comma_list_splitter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset asserted at time zero, then released once for the whole run.
  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Idle percentage of either side for the current phase.
  function automatic int idle_pct(input bit rx_side);
    case (phase)
      0:       return rx_side ? 86 : 17;
      1:       return rx_side ? 17 : 86;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void queue_result(input logic has, input logic [7:0] b,
                                       input logic iend, input logic bad,
                                       input logic lend);
    res_t r;
    r.has_byte    = has;
    r.out_byte    = has ? b : 8'h00;
    r.item_end    = iend;
    r.bad_quoting = bad;
    r.list_end    = lend;
    expected_results_q.insert(expected_results_q.size(), r);
  endfunction

  function automatic void clear_item();
    at_start  = 1'b1;
    in_quotes = 1'b0;
    held_v    = 1'b0;
    held_b    = 8'h00;
    esc_pend  = 1'b0;
  endfunction

  // Unescape one interior byte of a quoted item; 1 when a byte comes out.
  function automatic bit unescape(input logic [7:0] b, output logic [7:0] o);
    o = b;
    if (esc_pend) begin
      esc_pend = 1'b0;
      case (b)
        CH_T:    o = CH_TAB;
        CH_R:    o = CH_CR;
        CH_N:    o = CH_LF;
        default: o = b;
      endcase
      return 1'b1;
    end
    if (b == CH_BSLASH) begin
      esc_pend = 1'b1;
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_splitter_byte(input logic [7:0] b, input logic last);
    logic       comma_ends;
    logic       bad;
    logic       has;
    logic [7:0] o;
    comma_ends = (b == CH_COMMA) && !bs_odd;
    bs_odd     = (b == CH_BSLASH) ? !bs_odd : 1'b0;
    o          = 8'h00;
    if (comma_ends) begin
      bad = in_quotes && !(held_v && held_b == CH_QUOTE);
      queue_result(1'b0, 8'h00, 1'b1, bad, 1'b0);
      // comma closing the list: empty trailing item follows
      if (last) queue_result(1'b0, 8'h00, 1'b1, 1'b0, 1'b1);
      clear_item();
    end else if (at_start && b == CH_QUOTE) begin
      at_start  = 1'b0;
      in_quotes = 1'b1;
      held_v    = 1'b0;
      esc_pend  = 1'b0;
      // lone quote as the whole item
      if (last) queue_result(1'b0, 8'h00, 1'b1, 1'b1, 1'b1);
    end else if (at_start || !in_quotes) begin
      at_start = 1'b0;
      queue_result(1'b1, b, last, 1'b0, last);
    end else if (last) begin
      has = 1'b0;
      if (held_v) has = unescape(held_b, o);
      queue_result(has, o, 1'b1, b != CH_QUOTE, 1'b1);
    end else begin
      if (held_v && unescape(held_b, o)) queue_result(1'b1, o, 1'b0, 1'b0, 1'b0);
      held_b = b;
      held_v = 1'b1;
    end
    if (last) begin
      clear_item();
      bs_odd = 1'b0;
      lists_done++;
    end
  endfunction

  initial begin
    clear_item();
    bs_odd = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, holds each until its transfer.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : driver
    list_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_splitter_byte(in_tdata, in_tlast);
        accepted_cnt <= accepted_cnt + 1;
      end
      // a byte on offer stays put until it is taken
      if (!in_tvalid || in_tready) begin
        if (list_bytes_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          nxt = list_bytes_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.data;
          in_tlast  <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver ready: random stalls, plus one long hold-off in the flat-out phase
  // so the result queue fills and in_tready drops.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (!hold_done && phase == 2 && accepted_cnt >= hold_at) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct(1'b1));
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every result transfer is checked against the oldest prediction.
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results_q.size() == 0) begin
        $error("result with nothing expected: out_byte %0d, tuser %b, tlast %b",
               out_tdata, out_tuser, out_tlast);
        err_cnt++;
      end else begin
        want = expected_results_q.pop_front();
        check_field("has_byte",    want.has_byte,    out_tuser[0]);
        check_field("out_byte",    want.out_byte,    out_tdata);
        check_field("item_end",    want.item_end,    out_tuser[1]);
        check_field("bad_quoting", want.bad_quoting, out_tuser[2]);
        check_field("list_end",    want.list_end,    out_tlast);
        results_seen++;
        if (want.bad_quoting) bad_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles without any transfer.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b, input logic last);
    list_byte_t lb;
    lb.data = b;
    lb.last = last;
    list_bytes_q.insert(list_bytes_q.size(), lb);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endtask

  // Any byte, leaning on the characters the splitter reacts to.
  function automatic logic [7:0] noise_byte();
    if ($urandom_range(99) >= 40) return 8'($urandom_range(255));
    case ($urandom_range(5))
      0:       return CH_COMMA;
      1:       return CH_BSLASH;
      2:       return CH_QUOTE;
      3:       return CH_T;
      4:       return CH_R;
      default: return CH_N;
    endcase
  endfunction

  // Interior byte of a quoted item that neither splits nor escapes.
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    if ($urandom_range(7) == 0) return CH_QUOTE;
    do b = 8'($urandom_range(255)); while (b == CH_COMMA || b == CH_BSLASH);
    return b;
  endfunction

  // Byte following a backslash inside quotes.
  function automatic logic [7:0] escaped_byte();
    case ($urandom_range(6))
      0:       return CH_T;
      1:       return CH_R;
      2:       return CH_N;
      3:       return CH_QUOTE;
      4:       return CH_BSLASH;
      5:       return CH_COMMA;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One random list: mostly well-formed items, some pure noise.
  task automatic add_random_list();
    logic [7:0] body[$];
    int         n_items;
    int         len;
    if ($urandom_range(99) < 20) begin
      len = $urandom_range(1, 8);
      repeat (len) body.insert(body.size(), noise_byte());
    end else begin
      n_items = $urandom_range(1, 4);
      for (int i = 0; i < n_items; i++) begin
        if (i > 0) body.insert(body.size(), CH_COMMA);
        case ($urandom_range(9))
          0, 1, 2: begin  // unquoted, raw content
            len = $urandom_range(0, 4);
            repeat (len) body.insert(body.size(), noise_byte());
          end
          3, 4, 5, 6, 7: begin  // quoted, properly closed
            body.insert(body.size(), CH_QUOTE);
            len = $urandom_range(0, 4);
            repeat (len) begin
              if ($urandom_range(3) == 0) begin
                body.insert(body.size(), CH_BSLASH);
                body.insert(body.size(), escaped_byte());
              end else begin
                body.insert(body.size(), plain_byte());
              end
            end
            body.insert(body.size(), CH_QUOTE);
          end
          8: begin  // quoted, closing quote missing
            body.insert(body.size(), CH_QUOTE);
            len = $urandom_range(0, 3);
            repeat (len) body.insert(body.size(), plain_byte());
            if ($urandom_range(1)) body.insert(body.size(), CH_BSLASH);
          end
          default: ;  // empty item
        endcase
      end
      if ($urandom_range(99) < 15) body.insert(body.size(), CH_COMMA);
    end
    if (body.size() == 0) body.insert(body.size(), noise_byte());
    foreach (body[i]) push_byte(body[i], i == body.size() - 1);
  endtask

  task automatic add_random_bytes(input int n);
    int target;
    target = list_bytes_q.size() + n;
    while (list_bytes_q.size() < target) add_random_list();
  endtask

  task automatic wait_all_done();
    while (list_bytes_q.size() != 0 || in_tvalid || expected_results_q.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    // Directed lists first
    add_text("a");                  // single raw byte
    add_text(",");                  // comma closing the list
    add_text("\"");                 // lone quote
    add_text("\"\\t\\r\\n\"");      // tab, CR, LF escapes
    add_text("\"ab");               // missing closing quote
    add_text("\"a\\");              // trailing lone backslash in quotes
    add_text("x\\,,");              // escaped comma, then trailing comma
    add_text(",y");                 // empty first item
    push_byte(8'h00, 1'b0);         // byte extremes
    push_byte(8'hFF, 1'b1);
    add_random_bytes(PHASE_BYTES);

    @(negedge clk);
    wait_all_done();
    phase = 1;
    add_random_bytes(PHASE_BYTES);

    wait_all_done();
    phase   = 2;
    hold_at = accepted_cnt + 40;
    add_random_bytes(PHASE_BYTES);

    wait_all_done();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d lists, %0d of them flagged bad quoting.",
             results_seen, lists_done, bad_seen);
    $display("Idling swapped between sides, then full rate with one long receiver stall.");
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/escl_pkg.sv
src/escl_decode.sv
src/escl_result_fifo.sv
src/escaped_comma_list_splitter.sv
bench/tb_top.sv
